[rtl/panned_sample_mixer_assert.svh]
// ----------------------------------------------------------------------------
// panned_sample_mixer_assert.svh
// Assertion macros for the panned sample mixer. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PANNED_SAMPLE_MIXER_ASSERT_SVH
`define PANNED_SAMPLE_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define PSM_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define PSM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`else

`define PSM_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define PSM_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

[rtl/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants of the panned sample mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MIX_BITS_DEF    = 24;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_FRAC       = 14;
    localparam int POS_BITS        = 25;
    localparam int PEAK_BITS       = 16;
    localparam int CHAN_BITS       = 2;
    localparam int QUEUE_DEPTH     = 4;
    localparam int APB_ADDR_BITS   = 5;
    localparam int APB_DATA_BITS   = 32;
    localparam int REG_IDX_BITS    = APB_ADDR_BITS - 2;

    localparam logic [CHAN_BITS-1:0] CHAN_STEREO = 2'd2;
    localparam logic [PEAK_BITS-1:0] PEAK_MAX    = 16'hFFFF;

    // Register indexes; byte address is four times the index.
    localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_CHANNELS = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_OUTPUT_CHANNELS = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MAIN_GAIN       = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_LEFT_GAIN       = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_RIGHT_GAIN      = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_TOTAL_SAMPLES   = 3'd5;

    localparam logic [CHAN_BITS-1:0] RST_CHANNELS = 2'd1;
    localparam logic [GAIN_BITS-1:0] RST_GAIN     = 16'd16384;

    typedef enum logic [1:0] {
        MODE_MIX   = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_SEEK  = 2'd3
    } t_mode;

    // Encoded as {source is stereo, output is stereo}.
    typedef enum logic [1:0] {
        ROUTE_MONO_MONO     = 2'd0,
        ROUTE_MONO_STEREO   = 2'd1,
        ROUTE_STEREO_MONO   = 2'd2,
        ROUTE_STEREO_STEREO = 2'd3
    } t_route;

    typedef struct packed {
        logic [CHAN_BITS-1:0] source_channels;
        logic [CHAN_BITS-1:0] output_channels;
        logic [GAIN_BITS-1:0] main_gain;
        logic [GAIN_BITS-1:0] left_gain;
        logic [GAIN_BITS-1:0] right_gain;
        logic [POS_BITS-1:0]  total_samples;
    } t_cfg;

    // Per-transaction control decided by the front end.
    typedef struct packed {
        logic                 mix;
        t_route               route;
        logic [PEAK_BITS-1:0] peak_level;
        logic                 peak_valid;
        logic                 playing;
        logic [POS_BITS-1:0]  position;
    } t_job_ctrl;

endpackage

`default_nettype wire

[rtl/psm_regs.sv]
// ----------------------------------------------------------------------------
// psm_regs
// APB configuration registers of the panned sample mixer.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_regs
    import psm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output t_cfg                          o_cfg
);

    t_cfg r_cfg;
    logic [REG_IDX_BITS-1:0] index;
    logic wr_en;

    assign index  = paddr[APB_ADDR_BITS-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_channels <= RST_CHANNELS;
            r_cfg.output_channels <= RST_CHANNELS;
            r_cfg.main_gain       <= RST_GAIN;
            r_cfg.left_gain       <= RST_GAIN;
            r_cfg.right_gain      <= RST_GAIN;
            r_cfg.total_samples   <= '0;
        end else if (wr_en) begin
            unique case (index)
                REG_SOURCE_CHANNELS: r_cfg.source_channels <= pwdata[CHAN_BITS-1:0];
                REG_OUTPUT_CHANNELS: r_cfg.output_channels <= pwdata[CHAN_BITS-1:0];
                REG_MAIN_GAIN:       r_cfg.main_gain       <= pwdata[GAIN_BITS-1:0];
                REG_LEFT_GAIN:       r_cfg.left_gain       <= pwdata[GAIN_BITS-1:0];
                REG_RIGHT_GAIN:      r_cfg.right_gain      <= pwdata[GAIN_BITS-1:0];
                REG_TOTAL_SAMPLES:   r_cfg.total_samples   <= pwdata[POS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_SOURCE_CHANNELS: prdata = APB_DATA_BITS'(r_cfg.source_channels);
            REG_OUTPUT_CHANNELS: prdata = APB_DATA_BITS'(r_cfg.output_channels);
            REG_MAIN_GAIN:       prdata = APB_DATA_BITS'(r_cfg.main_gain);
            REG_LEFT_GAIN:       prdata = APB_DATA_BITS'(r_cfg.left_gain);
            REG_RIGHT_GAIN:      prdata = APB_DATA_BITS'(r_cfg.right_gain);
            REG_TOTAL_SAMPLES:   prdata = APB_DATA_BITS'(r_cfg.total_samples);
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/psm_front.sv]
// ----------------------------------------------------------------------------
// psm_front
// Accepts transactions, keeps play state, position and block peak, and
// decides for each frame whether and how it is mixed.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_front
    import psm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  t_cfg                               i_cfg,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_mode,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_right,
    input  wire logic                          i_block_last,
    input  wire logic [POS_BITS-1:0]           i_seek_position,
    output t_job_ctrl                          o_ctrl
);

    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic                 r_playing, n_playing;
    logic [PEAK_BITS-1:0] r_peak, n_peak;

    t_mode                mode;
    logic                 src_stereo;
    logic                 out_stereo;
    logic [1:0]           step;
    logic [POS_BITS:0]    pos_sum;
    logic                 can_mix;
    logic [PEAK_BITS-1:0] mag_l, mag_r, peak_new;
    logic [PEAK_BITS-1:0] peak_out;
    logic                 peak_ok;

    // Absolute value of a sample, clipped to the peak meter range.
    function automatic logic [PEAK_BITS-1:0] peak_mag(input logic signed [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS:0] mag;
        mag = s[SAMPLE_BITS-1] ? ((SAMPLE_BITS+1)'(0) - (SAMPLE_BITS+1)'(s))
                               : (SAMPLE_BITS+1)'(s);
        if (32'(mag) > 32'(PEAK_MAX)) begin
            return PEAK_MAX;
        end
        return PEAK_BITS'(mag);
    endfunction

    assign mode       = t_mode'(i_mode);
    assign src_stereo = (i_cfg.source_channels == CHAN_STEREO);
    assign out_stereo = (i_cfg.output_channels == CHAN_STEREO);
    assign step       = src_stereo ? 2'd2 : 2'd1;
    assign pos_sum    = {1'b0, r_pos} + (POS_BITS+1)'(step);
    assign can_mix    = r_playing && (pos_sum <= {1'b0, i_cfg.total_samples});
    assign mag_l      = peak_mag(i_sample_left);
    assign mag_r      = src_stereo ? peak_mag(i_sample_right) : '0;

    always_comb begin
        peak_new = r_peak;
        if (mag_l > peak_new) begin
            peak_new = mag_l;
        end
        if (mag_r > peak_new) begin
            peak_new = mag_r;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_playing = r_playing;
        n_peak    = r_peak;
        peak_out  = '0;
        peak_ok   = 1'b0;
        unique case (mode)
            MODE_MIX: begin
                if (can_mix) begin
                    n_pos     = pos_sum[POS_BITS-1:0];
                    n_playing = (pos_sum[POS_BITS-1:0] < i_cfg.total_samples);
                    n_peak    = peak_new;
                end
                if (i_block_last) begin
                    peak_out = can_mix ? peak_new : r_peak;
                    peak_ok  = 1'b1;
                    n_peak   = '0;
                end
            end
            MODE_START: n_playing = 1'b1;
            MODE_STOP:  n_playing = 1'b0;
            MODE_SEEK:  n_pos     = {i_seek_position[POS_BITS-1:1], 1'b0};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_playing <= 1'b0;
            r_peak    <= '0;
        end else if (i_accept) begin
            r_pos     <= n_pos;
            r_playing <= n_playing;
            r_peak    <= n_peak;
        end
    end

    always_comb begin
        o_ctrl.mix        = (mode == MODE_MIX) && can_mix;
        o_ctrl.route      = t_route'({src_stereo, out_stereo});
        o_ctrl.peak_level = peak_out;
        o_ctrl.peak_valid = peak_ok;
        o_ctrl.playing    = n_playing;
        o_ctrl.position   = n_pos;
    end

endmodule

`default_nettype wire

[rtl/psm_queue.sv]
// ----------------------------------------------------------------------------
// psm_queue
// Small first-in first-out queue between the front end and the mix datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/psm_back.sv]
// ----------------------------------------------------------------------------
// psm_back
// Mix datapath: gain multiply stage, then scale, accumulate and saturate
// into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_back
    import psm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MIX_BITS    = MIX_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  t_cfg                               i_cfg,
    input  wire logic                          i_valid,
    input  t_job_ctrl                          i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_right,
    input  wire logic signed [MIX_BITS-1:0]    i_mix_left,
    input  wire logic signed [MIX_BITS-1:0]    i_mix_right,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [MIX_BITS-1:0]         o_out_left,
    output logic signed [MIX_BITS-1:0]         o_out_right,
    output logic [PEAK_BITS-1:0]               o_peak_level,
    output logic                               o_peak_valid,
    output logic                               o_is_playing,
    output logic [POS_BITS-1:0]                o_play_position
);

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int SHIFT     = SAMPLE_BITS + GAIN_FRAC - MIX_BITS;
    localparam int LSH       = (SHIFT < 0) ? -SHIFT : 0;
    localparam int RSH       = (SHIFT > 0) ? SHIFT : 0;
    localparam int EXT_BITS  = SUM_BITS + LSH;
    localparam int SCL_BITS  = MIX_BITS + 4;
    localparam int ACC_BITS  = MIX_BITS + 5;

    logic                        r_s1_valid;
    t_job_ctrl                   r_s1_ctrl;
    logic signed [PROD_BITS-1:0] r_prod_a, r_prod_b;
    logic signed [MIX_BITS-1:0]  r_s1_ml, r_s1_mr;

    logic                        r_out_valid;
    t_job_ctrl                   r_out_ctrl;
    logic signed [MIX_BITS-1:0]  r_out_left, r_out_right;

    logic                        out_free;
    logic [GAIN_BITS-1:0]        gain_a;
    logic signed [SAMPLE_BITS-1:0] samp_b;
    logic signed [PROD_BITS-1:0] n_prod_a, n_prod_b;
    logic signed [SUM_BITS-1:0]  sum_l, sum_r;
    logic signed [ACC_BITS-1:0]  acc_l, acc_r;
    logic                        out_stereo;
    logic signed [MIX_BITS-1:0]  n_out_left, n_out_right;

    // Scale from the product format to the mix format, rounding toward
    // minus infinity.
    function automatic logic signed [SCL_BITS-1:0] scale(input logic signed [SUM_BITS-1:0] v);
        logic signed [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(v) <<< LSH;
        return SCL_BITS'(ext >>> RSH);
    endfunction

    function automatic logic signed [MIX_BITS-1:0] saturate(input logic signed [ACC_BITS-1:0] v);
        logic [ACC_BITS-MIX_BITS:0] top;
        top = v[ACC_BITS-1:MIX_BITS-1];
        if ((top == '0) || (top == '1)) begin
            return v[MIX_BITS-1:0];
        end
        return v[ACC_BITS-1] ? {1'b1, {(MIX_BITS-1){1'b0}}} : {1'b0, {(MIX_BITS-1){1'b1}}};
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_valid && (!r_s1_valid || out_free);

    // Stage one: the two gain multiplies.
    assign gain_a   = (i_ctrl.route == ROUTE_MONO_MONO) ? i_cfg.main_gain : i_cfg.left_gain;
    assign samp_b   = ((i_ctrl.route == ROUTE_STEREO_MONO) || (i_ctrl.route == ROUTE_STEREO_STEREO))
                      ? i_sample_right : i_sample_left;
    assign n_prod_a = i_sample_left * $signed({1'b0, gain_a});
    assign n_prod_b = samp_b * $signed({1'b0, i_cfg.right_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_ctrl <= i_ctrl;
            r_prod_a  <= n_prod_a;
            r_prod_b  <= n_prod_b;
            r_s1_ml   <= i_mix_left;
            r_s1_mr   <= i_mix_right;
        end
    end

    // Stage two: combine, scale, accumulate and saturate.
    assign sum_l = SUM_BITS'(r_prod_a)
                 + ((r_s1_ctrl.route == ROUTE_STEREO_MONO) ? SUM_BITS'(r_prod_b) : '0);
    assign sum_r = SUM_BITS'(r_prod_b);
    assign acc_l = ACC_BITS'(r_s1_ml) + ACC_BITS'(scale(sum_l));
    assign acc_r = ACC_BITS'(r_s1_mr) + ACC_BITS'(scale(sum_r));
    assign out_stereo = (r_s1_ctrl.route == ROUTE_MONO_STEREO)
                     || (r_s1_ctrl.route == ROUTE_STEREO_STEREO);

    always_comb begin
        n_out_left  = r_s1_ctrl.mix ? saturate(acc_l) : r_s1_ml;
        n_out_right = '0;
        if (out_stereo) begin
            n_out_right = r_s1_ctrl.mix ? saturate(acc_r) : r_s1_mr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_ctrl  <= r_s1_ctrl;
            r_out_left  <= n_out_left;
            r_out_right <= n_out_right;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_left      = r_out_left;
    assign o_out_right     = r_out_right;
    assign o_peak_level    = r_out_ctrl.peak_level;
    assign o_peak_valid    = r_out_ctrl.peak_valid;
    assign o_is_playing    = r_out_ctrl.playing;
    assign o_play_position = r_out_ctrl.position;

endmodule

`default_nettype wire

[rtl/panned_sample_mixer.sv]
// ----------------------------------------------------------------------------
// panned_sample_mixer
// Mixes one mono or stereo source frame per transaction into a mono or
// stereo accumulator, with pan gains, 24-bit saturation and a block peak.
//
// Input channel: i_in_valid / o_in_stall carries mode, samples, accumulator
// values, block_last and seek_position. Output channel: o_out_valid /
// i_out_stall returns one result per input transaction, in order.
// Configuration goes through the APB port (pready always high); write it
// only while no transaction is in flight.
// Throughput is one transaction per cycle while the receiver does not stall.
// A result passes from the queue into the gain multiply registers, then
// through scaling and saturation into the output register.
// When the receiver stalls, the output register and the multiply stage hold
// their transactions, and up to four more wait in the queue before
// o_in_stall rises. Reset clears play state, position, peak and the
// registers to their defaults; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none
`include "panned_sample_mixer_assert.svh"

module panned_sample_mixer
    import psm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MIX_BITS    = MIX_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]      paddr,
    input  wire logic [APB_DATA_BITS-1:0]      pwdata,
    output logic      [APB_DATA_BITS-1:0]      prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_mode,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_right,
    input  wire logic signed [MIX_BITS-1:0]    i_mix_in_left,
    input  wire logic signed [MIX_BITS-1:0]    i_mix_in_right,
    input  wire logic                          i_block_last,
    input  wire logic [POS_BITS-1:0]           i_seek_position,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [MIX_BITS-1:0]         o_out_left,
    output logic signed [MIX_BITS-1:0]         o_out_right,
    output logic [PEAK_BITS-1:0]               o_peak_level,
    output logic                               o_peak_valid,
    output logic                               o_is_playing,
    output logic [POS_BITS-1:0]                o_play_position
);

    localparam int CTRL_BITS = $bits(t_job_ctrl);
    localparam int JOB_BITS  = CTRL_BITS + 2 * SAMPLE_BITS + 2 * MIX_BITS;

    t_cfg          cfg;
    t_job_ctrl     front_ctrl, q_ctrl;
    logic          accept;
    logic          q_full, q_empty, q_pop;
    logic [JOB_BITS-1:0] q_in, q_out;
    logic signed [SAMPLE_BITS-1:0] q_sl, q_sr;
    logic signed [MIX_BITS-1:0]    q_ml, q_mr;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    psm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    psm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_accept        (accept),
        .i_mode          (i_mode),
        .i_sample_left   (i_sample_left),
        .i_sample_right  (i_sample_right),
        .i_block_last    (i_block_last),
        .i_seek_position (i_seek_position),
        .o_ctrl          (front_ctrl)
    );

    assign q_in = {front_ctrl, i_sample_left, i_sample_right, i_mix_in_left, i_mix_in_right};

    psm_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {q_ctrl, q_sl, q_sr, q_ml, q_mr} = q_out;

    psm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MIX_BITS    (MIX_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (!q_empty),
        .i_ctrl          (q_ctrl),
        .i_sample_left   (q_sl),
        .i_sample_right  (q_sr),
        .i_mix_left      (q_ml),
        .i_mix_right     (q_mr),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_left      (o_out_left),
        .o_out_right     (o_out_right),
        .o_peak_level    (o_peak_level),
        .o_peak_valid    (o_peak_valid),
        .o_is_playing    (o_is_playing),
        .o_play_position (o_play_position)
    );

    // A result without a finished block carries no peak.
    `PSM_ASSERT_IMPLY(a_peak_only_on_block_end, i_clk, i_rst_n, o_out_valid && !o_peak_valid, o_peak_level == '0)
    // With a mono output mix the right channel of every result is zero.
    `PSM_ASSERT_IMPLY(a_mono_right_zero, i_clk, i_rst_n, o_out_valid && (cfg.output_channels != CHAN_STEREO), o_out_right == '0)
    // An accepted transaction is waiting in the queue on the next cycle.
    `PSM_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, accept, !q_empty)

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the panned sample mixer. It runs a directed
// table first: reset values, saturation extremes, every mode and routing,
// and the end-of-source cases. Several random phases follow, each with its
// own routing, gains and source length. Results are checked in order
// against table values or an in-bench model. Both channels idle and stall at
// random, and one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psm_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_WAIT     = 6;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 48;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int GAIN_SHIFT   = SAMPLE_BITS_DEF + GAIN_FRAC - MIX_BITS_DEF;
    localparam longint MIX_HI   = (longint'(1) <<< (MIX_BITS_DEF - 1)) - 1;
    localparam longint MIX_LO   = -(longint'(1) <<< (MIX_BITS_DEF - 1));
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;

    typedef struct {
        t_mode                             mode;
        logic signed [SAMPLE_BITS_DEF-1:0] sl;
        logic signed [SAMPLE_BITS_DEF-1:0] sr;
        logic signed [MIX_BITS_DEF-1:0]    ml;
        logic signed [MIX_BITS_DEF-1:0]    mr;
        logic                              last;
        logic [POS_BITS-1:0]               seek;
    } t_mix_item;

    typedef struct {
        logic signed [MIX_BITS_DEF-1:0] out_l;
        logic signed [MIX_BITS_DEF-1:0] out_r;
        logic [PEAK_BITS-1:0]           peak;
        logic                           peak_ok;
        logic                           playing;
        logic [POS_BITS-1:0]            pos;
    } t_mix_result;

    typedef struct {
        bit                        is_cfg;
        logic [REG_IDX_BITS-1:0]   reg_idx;
        logic [APB_DATA_BITS-1:0]  reg_val;
        t_mix_item                 it;
        bit                        typed;
        t_mix_result               want;
    } t_plan_row;

    logic                         i_clk;
    logic                         i_rst_n         = 1'b0;
    logic                         psel            = 1'b0;
    logic                         penable         = 1'b0;
    logic                         pwrite          = 1'b0;
    logic [APB_ADDR_BITS-1:0]     paddr           = '0;
    logic [APB_DATA_BITS-1:0]     pwdata          = '0;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;
    logic                         i_in_valid      = 1'b0;
    logic                         o_in_stall;
    logic [1:0]                   i_mode          = MODE_MIX;
    logic signed [SAMPLE_BITS_DEF-1:0] i_sample_left  = '0;
    logic signed [SAMPLE_BITS_DEF-1:0] i_sample_right = '0;
    logic signed [MIX_BITS_DEF-1:0]    i_mix_in_left  = '0;
    logic signed [MIX_BITS_DEF-1:0]    i_mix_in_right = '0;
    logic                         i_block_last    = 1'b0;
    logic [POS_BITS-1:0]          i_seek_position = '0;
    logic                         o_out_valid;
    logic                         i_out_stall     = 1'b0;
    logic signed [MIX_BITS_DEF-1:0] o_out_left;
    logic signed [MIX_BITS_DEF-1:0] o_out_right;
    logic [PEAK_BITS-1:0]         o_peak_level;
    logic                         o_peak_valid;
    logic                         o_is_playing;
    logic [POS_BITS-1:0]          o_play_position;

    // Shadow copy of the registers and of the mixer state.
    logic [CHAN_BITS-1:0] cfg_src_ch     = RST_CHANNELS;
    logic [CHAN_BITS-1:0] cfg_out_ch     = RST_CHANNELS;
    logic [GAIN_BITS-1:0] cfg_main_gain  = RST_GAIN;
    logic [GAIN_BITS-1:0] cfg_left_gain  = RST_GAIN;
    logic [GAIN_BITS-1:0] cfg_right_gain = RST_GAIN;
    logic [POS_BITS-1:0]  cfg_total      = '0;
    logic [POS_BITS-1:0]  pos_st         = '0;
    logic                 play_st        = 1'b0;
    logic [PEAK_BITS-1:0] peak_st        = '0;

    t_mix_result mix_expect_q[$];
    t_mix_result due;
    t_plan_row   plan[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          in_burst = 1'b0;
    bit          out_burst = 1'b0;
    bit          hold_req = 1'b0;

    panned_sample_mixer u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic longint sat_mix(input longint v);
        if (v > MIX_HI) return MIX_HI;
        if (v < MIX_LO) return MIX_LO;
        return v;
    endfunction

    // Q3.29 product down to Q1.23; the arithmetic shift floors.
    function automatic logic signed [MIX_BITS_DEF-1:0] mix_gain(input longint acc,
                                                               input longint prod);
        return MIX_BITS_DEF'(sat_mix(acc + (prod >>> GAIN_SHIFT)));
    endfunction

    function automatic void track_peak(input longint s);
        longint a;
        a = (s < 0) ? -s : s;
        if (a > PEAK_MAX) a = PEAK_MAX;
        if (a > peak_st) peak_st = PEAK_BITS'(a);
    endfunction

    function automatic t_mix_result predict_mix(input t_mix_item it);
        t_mix_result r;
        logic   src_st;
        logic   out_st;
        longint step;
        longint sl;
        longint sr;
        longint gm;
        longint gl;
        longint gr;
        src_st = (cfg_src_ch == CHAN_STEREO);
        out_st = (cfg_out_ch == CHAN_STEREO);
        step = src_st ? 2 : 1;
        sl = it.sl;
        sr = it.sr;
        gm = cfg_main_gain;
        gl = cfg_left_gain;
        gr = cfg_right_gain;
        r.out_l = it.ml;
        r.out_r = out_st ? it.mr : '0;
        r.peak = '0;
        r.peak_ok = 1'b0;
        case (it.mode)
            MODE_MIX: begin
                if (play_st && longint'(pos_st) + step <= longint'(cfg_total)) begin
                    if (!src_st && !out_st) begin
                        r.out_l = mix_gain(it.ml, sl * gm);
                    end else if (!src_st) begin
                        r.out_l = mix_gain(it.ml, sl * gl);
                        r.out_r = mix_gain(it.mr, sl * gr);
                    end else if (!out_st) begin
                        r.out_l = mix_gain(it.ml, sl * gl + sr * gr);
                    end else begin
                        r.out_l = mix_gain(it.ml, sl * gl);
                        r.out_r = mix_gain(it.mr, sr * gr);
                    end
                    track_peak(sl);
                    if (src_st) track_peak(sr);
                    pos_st = pos_st + POS_BITS'(step);
                    if (pos_st >= cfg_total) play_st = 1'b0;
                end
                if (it.last) begin
                    r.peak = peak_st;
                    r.peak_ok = 1'b1;
                    peak_st = '0;
                end
            end
            MODE_START: play_st = 1'b1;
            MODE_STOP:  play_st = 1'b0;
            default:    pos_st = {it.seek[POS_BITS-1:1], 1'b0};
        endcase
        r.playing = play_st;
        r.pos = pos_st;
        return r;
    endfunction

    function automatic t_plan_row itm(input t_mode m, input int sl, input int sr,
                                      input int ml, input int mr, input bit last,
                                      input int seek);
        t_plan_row row;
        row.is_cfg = 1'b0;
        row.typed = 1'b0;
        row.it.mode = m;
        row.it.sl = SAMPLE_BITS_DEF'(sl);
        row.it.sr = SAMPLE_BITS_DEF'(sr);
        row.it.ml = MIX_BITS_DEF'(ml);
        row.it.mr = MIX_BITS_DEF'(mr);
        row.it.last = last;
        row.it.seek = POS_BITS'(seek);
        return row;
    endfunction

    function automatic t_plan_row with_exp(input t_plan_row row, input int ol, input int orr,
                                           input int pk, input bit pv, input bit pl,
                                           input int pos);
        row.typed = 1'b1;
        row.want.out_l = MIX_BITS_DEF'(ol);
        row.want.out_r = MIX_BITS_DEF'(orr);
        row.want.peak = PEAK_BITS'(pk);
        row.want.peak_ok = pv;
        row.want.playing = pl;
        row.want.pos = POS_BITS'(pos);
        return row;
    endfunction

    function automatic t_plan_row reg_wr(input logic [REG_IDX_BITS-1:0] idx,
                                         input logic [APB_DATA_BITS-1:0] val);
        t_plan_row row;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};
            1: return {1'b0, {(SAMPLE_BITS_DEF-1){1'b1}}};
            default: return SAMPLE_BITS_DEF'($urandom);
        endcase
    endfunction

    function automatic logic signed [MIX_BITS_DEF-1:0] draw_accum();
        case ($urandom_range(0, 7))
            0: return MIX_BITS_DEF'(MIX_LO);
            1: return MIX_BITS_DEF'(MIX_HI);
            default: return MIX_BITS_DEF'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] draw_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return GAIN_MAX;
            2: return RST_GAIN;
            default: return GAIN_BITS'($urandom);
        endcase
    endfunction

    // Any channel count other than two means mono.
    function automatic logic [CHAN_BITS-1:0] pick_chan(input logic stereo);
        int sel;
        sel = $urandom_range(0, 2);
        if (stereo) return CHAN_STEREO;
        return (sel == 0) ? 2'd0 : (sel == 1) ? 2'd1 : 2'd3;
    endfunction

    // Mostly frames, with starts (more often when idle), stops and seeks.
    function automatic t_plan_row draw_mix_row();
        t_plan_row row;
        int        r;
        int        hi;
        t_mode     m;
        r = $urandom_range(0, 99);
        if (!play_st && r < 30) m = MODE_START;
        else if (r < 84) m = MODE_MIX;
        else if (r < 88) m = MODE_STOP;
        else if (r < 96) m = MODE_SEEK;
        else m = MODE_START;
        row = itm(m, 0, 0, 0, 0, 1'b0, 0);
        row.it.sl = draw_sample();
        row.it.sr = draw_sample();
        row.it.ml = draw_accum();
        row.it.mr = draw_accum();
        row.it.last = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 4) < 3) begin
            hi = int'(cfg_total) + 3;
            if (hi > int'(POS_MAX)) hi = int'(POS_MAX);
            row.it.seek = POS_BITS'($urandom_range(0, hi));
        end else begin
            row.it.seek = POS_BITS'($urandom);
        end
        return row;
    endfunction

    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SOURCE_CHANNELS: cfg_src_ch = val[CHAN_BITS-1:0];
            REG_OUTPUT_CHANNELS: cfg_out_ch = val[CHAN_BITS-1:0];
            REG_MAIN_GAIN:       cfg_main_gain = val[GAIN_BITS-1:0];
            REG_LEFT_GAIN:       cfg_left_gain = val[GAIN_BITS-1:0];
            REG_RIGHT_GAIN:      cfg_right_gain = val[GAIN_BITS-1:0];
            REG_TOTAL_SAMPLES:   cfg_total = val[POS_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input t_plan_row row);
        int          gap;
        t_mix_result res;
        gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode <= row.it.mode;
        i_sample_left <= row.it.sl;
        i_sample_right <= row.it.sr;
        i_mix_in_left <= row.it.ml;
        i_mix_in_right <= row.it.mr;
        i_block_last <= row.it.last;
        i_seek_position <= row.it.seek;
        do @(posedge i_clk); while (o_in_stall);
        res = predict_mix(row.it);
        mix_expect_q.push_back(row.typed ? row.want : res);
    endtask

    task automatic wait_mix_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (mix_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mix_expect_q.size() == 0) begin
                $display("%0t ns: result arrived with no transaction outstanding", $time);
                fail_count++;
            end else begin
                due = mix_expect_q.pop_front();
                check_field("out_left", due.out_l, o_out_left);
                check_field("out_right", due.out_r, o_out_right);
                check_field("peak_level", due.peak, o_peak_level);
                check_field("peak_valid", due.peak_ok, o_peak_valid);
                check_field("is_playing", due.playing, o_is_playing);
                check_field("play_position", due.pos, o_play_position);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Output side: random stalls per result, quiet stretches, and one long
    // hold-off on request that fills the block up to its input.
    initial begin
        int w;
        int taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_req = 1'b0;
            end
            w = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (w) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
            if (taken % 64 == 0) out_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int                   phase;
        int                   n;
        t_route               route;
        logic [GAIN_BITS-1:0] g_main;
        logic [GAIN_BITS-1:0] g_left;
        logic [GAIN_BITS-1:0] g_right;
        logic [POS_BITS-1:0]  total_set;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset routing is mono to mono with an empty source.
        plan.push_back(with_exp(itm(MODE_MIX, 1234, -5, 8388607, -8388608, 0, 0),
                                8388607, 0, 0, 0, 0, 0));
        plan.push_back(with_exp(itm(MODE_MIX, -32768, 32767, -8388608, 77, 1, 0),
                                -8388608, 0, 0, 1, 0, 0));
        // Start with the position already at the end keeps the flag set.
        plan.push_back(with_exp(itm(MODE_START, 0, 0, 0, 5, 0, 0), 0, 0, 0, 0, 1, 0));
        plan.push_back(with_exp(itm(MODE_MIX, 32767, 32767, 42, 9, 1, 0),
                                42, 0, 0, 1, 1, 0));
        plan.push_back(with_exp(itm(MODE_SEEK, 0, 0, 0, 0, 0, int'(POS_MAX)),
                                0, 0, 0, 0, 1, int'(POS_MAX) - 1));
        plan.push_back(with_exp(itm(MODE_STOP, 0, 0, 0, 0, 0, 0),
                                0, 0, 0, 0, 0, int'(POS_MAX) - 1));
        plan.push_back(reg_wr(REG_TOTAL_SAMPLES, POS_MAX));
        plan.push_back(reg_wr(REG_MAIN_GAIN, GAIN_MAX));
        plan.push_back(with_exp(itm(MODE_SEEK, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        plan.push_back(with_exp(itm(MODE_START, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 1, 0));
        // Full-scale samples at full gain saturate both ways.
        plan.push_back(with_exp(itm(MODE_MIX, -32768, 0, -8388608, 0, 0, 0),
                                -8388608, 0, 0, 0, 1, 1));
        plan.push_back(with_exp(itm(MODE_MIX, 32767, 0, 8388607, 0, 1, 0),
                                8388607, 0, 32768, 1, 1, 2));
        plan.push_back(reg_wr(REG_SOURCE_CHANNELS, CHAN_STEREO));
        plan.push_back(reg_wr(REG_OUTPUT_CHANNELS, CHAN_STEREO));
        plan.push_back(reg_wr(REG_LEFT_GAIN, 0));
        plan.push_back(reg_wr(REG_RIGHT_GAIN, GAIN_MAX));
        plan.push_back(itm(MODE_MIX, 20000, -20000, 1000, -1000, 0, 0));
        plan.push_back(reg_wr(REG_OUTPUT_CHANNELS, RST_CHANNELS));
        plan.push_back(itm(MODE_MIX, -32768, -32768, 0, 0, 0, 0));
        plan.push_back(reg_wr(REG_LEFT_GAIN, GAIN_MAX));
        plan.push_back(itm(MODE_MIX, 32767, 32767, -8388608, 3, 1, 0));
        plan.push_back(reg_wr(REG_SOURCE_CHANNELS, RST_CHANNELS));
        plan.push_back(reg_wr(REG_OUTPUT_CHANNELS, CHAN_STEREO));
        plan.push_back(reg_wr(REG_LEFT_GAIN, 12345));
        plan.push_back(reg_wr(REG_RIGHT_GAIN, RST_GAIN));
        plan.push_back(itm(MODE_MIX, -1, 1, -8388608, 8388607, 0, 0));
        // Short stereo source: play runs out, then restarts at the end.
        plan.push_back(reg_wr(REG_TOTAL_SAMPLES, 6));
        plan.push_back(reg_wr(REG_SOURCE_CHANNELS, CHAN_STEREO));
        plan.push_back(itm(MODE_SEEK, 0, 0, 0, 0, 0, 4));
        plan.push_back(itm(MODE_MIX, -300, 7000, 11, -11, 0, 0));
        plan.push_back(itm(MODE_MIX, 5, 5, 12, 13, 0, 0));
        plan.push_back(itm(MODE_START, 0, 0, 0, 0, 0, 0));
        plan.push_back(itm(MODE_MIX, 100, 200, 14, 15, 1, 0));
        plan.push_back(itm(MODE_SEEK, 0, 0, 0, 0, 0, 3));
        plan.push_back(itm(MODE_MIX, -2, 9, 0, 0, 0, 0));
        // One sample left but a stereo frame needs two.
        plan.push_back(reg_wr(REG_TOTAL_SAMPLES, 5));
        plan.push_back(itm(MODE_MIX, 4000, -4000, 1, 2, 0, 0));
        plan.push_back(itm(MODE_SEEK, 0, 0, 0, 0, 0, 1000));
        plan.push_back(itm(MODE_MIX, 1, 1, 3, 4, 1, 0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_mix_idle();
                apb_write(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i]);
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            g_main = draw_gain();
            g_left = draw_gain();
            g_right = draw_gain();
            case (phase)
                0: begin
                    route = ROUTE_MONO_MONO;
                    g_main = GAIN_MAX;
                    g_left = GAIN_MAX;
                    g_right = GAIN_MAX;
                    total_set = 200;
                end
                1: begin
                    route = ROUTE_MONO_STEREO;
                    g_main = '0;
                    g_left = '0;
                    g_right = '0;
                    total_set = POS_BITS'($urandom_range(50, 300));
                end
                2: begin
                    route = ROUTE_STEREO_MONO;
                    total_set = POS_MAX;
                end
                3: begin
                    route = ROUTE_STEREO_STEREO;
                    total_set = POS_BITS'($urandom_range(0, 400));
                end
                default: begin
                    route = t_route'($urandom_range(0, 3));
                    total_set = (phase == PHASES - 1) ? POS_BITS'($urandom)
                                                      : POS_BITS'($urandom_range(1, 400));
                end
            endcase
            wait_mix_idle();
            apb_write(REG_SOURCE_CHANNELS, pick_chan(route[1]));
            apb_write(REG_OUTPUT_CHANNELS, pick_chan(route[0]));
            apb_write(REG_MAIN_GAIN, g_main);
            apb_write(REG_LEFT_GAIN, g_left);
            apb_write(REG_RIGHT_GAIN, g_right);
            apb_write(REG_TOTAL_SAMPLES, total_set);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 75 == 0) in_burst = ($urandom_range(0, 3) == 0);
                if (phase == 3 && n == 120) hold_req = 1'b1;
                send_item(draw_mix_row());
            end
        end

        wait_mix_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/psm_pkg.sv
rtl/psm_regs.sv
rtl/psm_front.sv
rtl/psm_queue.sv
rtl/psm_back.sv
rtl/panned_sample_mixer.sv
tb/tb_top.sv
